FILE: design/cme_pkg.sv
`default_nettype none
package cme_pkg;

	localparam int unsigned MaxMessageBytes = 1024;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned BurstBytes = 5;

	localparam logic [2:0] OP_HEADER = 3'd0;
	localparam logic [2:0] OP_TOKEN_BYTE = 3'd1;
	localparam logic [2:0] OP_OPTION_HDR = 3'd2;
	localparam logic [2:0] OP_OPTION_BYTE = 3'd3;
	localparam logic [2:0] OP_PAYLOAD_START = 3'd4;
	localparam logic [2:0] OP_PAYLOAD_BYTE = 3'd5;
	localparam logic [2:0] OP_FINISH = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_DESCENDING = 2'd2;

	localparam logic [3:0] NIB_EXT1 = 4'd13;
	localparam logic [3:0] NIB_EXT2 = 4'd14;
	localparam logic [15:0] EXT1_OFFSET = 16'd13;
	localparam logic [15:0] EXT2_OFFSET = 16'd269;
	localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
	localparam logic [1:0] COAP_VERSION = 2'b01;

	typedef struct packed {
		logic [BurstBytes-1:0][7:0] bytes;
		logic [2:0] count;
		logic finish;
		logic [1:0] status;
		logic [15:0] size_base;
	} burst_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} ext_t;

	function automatic logic [3:0] nib_of(logic [15:0] v);
		logic [3:0] n;
		if (v < 16'd13) begin
			n = v[3:0];
		end else if (v < EXT2_OFFSET) begin
			n = NIB_EXT1;
		end else begin
			n = NIB_EXT2;
		end
		return n;
	endfunction

	function automatic ext_t ext_of(logic [15:0] v);
		ext_t e;
		logic [15:0] w;
		w = v - EXT2_OFFSET;
		e = '0;
		if (v < 16'd13) begin
			e.cnt = 2'd0;
		end else if (v < EXT2_OFFSET) begin
			e.cnt = 2'd1;
			e.b0 = v[7:0] - EXT1_OFFSET[7:0];
		end else begin
			e.cnt = 2'd2;
			e.b0 = w[15:8];
			e.b1 = w[7:0];
		end
		return e;
	endfunction

endpackage
`default_nettype wire

FILE: design/cme_if.sv
`default_nettype none
interface cme_in_if;
	logic valid;
	logic ready;
	logic [2:0] operation;
	logic [1:0] msg_type;
	logic [3:0] token_length;
	logic [7:0] code;
	logic [15:0] message_id;
	logic [15:0] option_number;
	logic [15:0] value_length;
	logic [7:0] data_byte;

	modport source(output valid, operation, msg_type, token_length, code, message_id,
		option_number, value_length, data_byte, input ready);
	modport sink(input valid, operation, msg_type, token_length, code, message_id,
		option_number, value_length, data_byte, output ready);
endinterface

interface cme_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic byte_valid;
	logic last;
	logic [1:0] status;
	logic [15:0] message_size;

	modport source(output valid, out_byte, byte_valid, last, status, message_size,
		input ready);
	modport sink(input valid, out_byte, byte_valid, last, status, message_size,
		output ready);
endinterface
`default_nettype wire

FILE: design/cme_front.sv
`default_nettype none
module cme_front #(
	parameter int unsigned MAX_MESSAGE_BYTES = cme_pkg::MaxMessageBytes
) (
	input wire logic clk,
	input wire logic arst_n,
	cme_in_if.sink in_ch,
	input wire logic push_ready,
	output logic push_valid,
	output cme_pkg::burst_t push_data
);

	localparam logic [17:0] MaxBytes = 18'(MAX_MESSAGE_BYTES);

	logic [15:0] ron_q, ron_n;
	logic [15:0] size_q, size_n;
	logic [1:0] err_q, err_n;
	logic want_push;
	logic accept;
	logic [15:0] delta;
	logic [3:0] dnib, lnib;
	cme_pkg::ext_t dext, lext;
	logic [7:0] opt_hdr;
	logic [4:0][7:0] opt_bytes;
	logic [17:0] size_ext;

	assign delta = in_ch.option_number - ron_q;
	assign dnib = cme_pkg::nib_of(delta);
	assign lnib = cme_pkg::nib_of(in_ch.value_length);
	assign dext = cme_pkg::ext_of(delta);
	assign lext = cme_pkg::ext_of(in_ch.value_length);
	assign opt_hdr = {dnib, lnib};
	assign size_ext = {2'b00, size_q};

	always_comb begin
		opt_bytes = '0;
		opt_bytes[0] = opt_hdr;
		unique case (dext.cnt)
			2'd1: begin
				opt_bytes[1] = dext.b0;
				opt_bytes[2] = lext.b0;
				opt_bytes[3] = lext.b1;
			end
			2'd2: begin
				opt_bytes[1] = dext.b0;
				opt_bytes[2] = dext.b1;
				opt_bytes[3] = lext.b0;
				opt_bytes[4] = lext.b1;
			end
			default: begin
				opt_bytes[1] = lext.b0;
				opt_bytes[2] = lext.b1;
			end
		endcase
	end

	always_comb begin
		ron_n = ron_q;
		size_n = size_q;
		err_n = err_q;
		want_push = 1'b0;
		push_data = '0;
		push_data.status = err_q;
		push_data.size_base = size_q;
		push_data.count = 3'd1;
		unique case (in_ch.operation)
			cme_pkg::OP_HEADER: begin
				ron_n = '0;
				size_n = '0;
				err_n = cme_pkg::ST_OK;
				push_data.status = cme_pkg::ST_OK;
				push_data.size_base = '0;
				if (18'd4 >= MaxBytes) begin
					err_n = cme_pkg::ST_TOO_LONG;
				end else begin
					want_push = 1'b1;
					push_data.count = 3'd4;
					push_data.bytes[0] = {cme_pkg::COAP_VERSION, in_ch.msg_type,
						in_ch.token_length};
					push_data.bytes[1] = in_ch.code;
					push_data.bytes[2] = in_ch.message_id[15:8];
					push_data.bytes[3] = in_ch.message_id[7:0];
					size_n = 16'd4;
				end
			end
			cme_pkg::OP_FINISH: begin
				want_push = 1'b1;
				push_data.finish = 1'b1;
			end
			cme_pkg::OP_TOKEN_BYTE, cme_pkg::OP_OPTION_BYTE, cme_pkg::OP_PAYLOAD_BYTE: begin
				if (err_q == cme_pkg::ST_OK) begin
					if (size_ext + 18'd1 >= MaxBytes) begin
						err_n = cme_pkg::ST_TOO_LONG;
					end else begin
						want_push = 1'b1;
						push_data.bytes[0] = in_ch.data_byte;
						size_n = size_q + 16'd1;
					end
				end
			end
			cme_pkg::OP_OPTION_HDR: begin
				if (err_q == cme_pkg::ST_OK) begin
					if (in_ch.option_number < ron_q) begin
						err_n = cme_pkg::ST_DESCENDING;
					end else if (size_ext + 18'd5 + {2'b00, in_ch.value_length}
							>= MaxBytes) begin
						err_n = cme_pkg::ST_TOO_LONG;
					end else begin
						want_push = 1'b1;
						push_data.bytes = opt_bytes;
						push_data.count = 3'd1 + {1'b0, dext.cnt} + {1'b0, lext.cnt};
						size_n = size_q + 16'd1 + {14'd0, dext.cnt} + {14'd0, lext.cnt};
						ron_n = in_ch.option_number;
					end
				end
			end
			cme_pkg::OP_PAYLOAD_START: begin
				if (err_q == cme_pkg::ST_OK && in_ch.value_length != 16'd0) begin
					if (size_ext + 18'd1 + {2'b00, in_ch.value_length} >= MaxBytes) begin
						err_n = cme_pkg::ST_TOO_LONG;
					end else begin
						want_push = 1'b1;
						push_data.bytes[0] = cme_pkg::PAYLOAD_MARKER;
						size_n = size_q + 16'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ch.ready = push_ready;
	assign accept = in_ch.valid && push_ready;
	assign push_valid = accept && want_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ron_q <= '0;
			size_q <= '0;
			err_q <= cme_pkg::ST_OK;
		end else if (accept) begin
			ron_q <= ron_n;
			size_q <= size_n;
			err_q <= err_n;
		end
	end

endmodule
`default_nettype wire

FILE: design/cme_queue.sv
`default_nettype none
module cme_queue #(
	parameter int unsigned DEPTH = cme_pkg::QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	input wire cme_pkg::burst_t push_data,
	output logic push_ready,
	output logic head_valid,
	output cme_pkg::burst_t head_data,
	input wire logic pop
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	cme_pkg::burst_t entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != FullCnt);
	assign head_valid = (cnt_q != '0);
	assign head_data = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/cme_back.sv
`default_nettype none
module cme_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic head_valid,
	input wire cme_pkg::burst_t head_data,
	output logic pop,
	cme_out_if.source out_ch
);

	logic [2:0] idx_q;
	logic is_last;
	logic xfer;

	assign is_last = (idx_q == head_data.count - 3'd1);
	assign xfer = out_ch.valid && out_ch.ready;
	assign pop = xfer && is_last;

	assign out_ch.valid = head_valid;
	assign out_ch.out_byte = head_data.bytes[idx_q];
	assign out_ch.byte_valid = !head_data.finish;
	assign out_ch.last = is_last;
	assign out_ch.status = head_data.status;
	assign out_ch.message_size = head_data.finish ? head_data.size_base
		: head_data.size_base + {13'd0, idx_q} + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (xfer) begin
			idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

FILE: design/coap_message_encoder_core.sv
// Each result of an item enters the item queue on its transfer and is offered
// from the queue head. Throughput: one input item per cycle while the queue has
// room; the output moves one byte per cycle while ready, so a header gives 4
// bytes and an option header 1 to 5. Items that give no result take no entry.
// Reset: arst_n clears option number, size count, error status and the queue.
`default_nettype none
module coap_message_encoder_core #(
	parameter int unsigned MAX_MESSAGE_BYTES = cme_pkg::MaxMessageBytes,
	parameter int unsigned QUEUE_DEPTH = cme_pkg::QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	cme_in_if.sink in_ch,
	cme_out_if.source out_ch
);

	logic push_valid, push_ready;
	cme_pkg::burst_t push_data;
	logic head_valid, pop;
	cme_pkg::burst_t head_data;

	cme_front #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.push_ready(push_ready),
		.push_valid(push_valid),
		.push_data(push_data)
	);

	cme_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_data(push_data),
		.push_ready(push_ready),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(pop)
	);

	cme_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(pop),
		.out_ch(out_ch)
	);

endmodule
`default_nettype wire

FILE: design/cme_checker.sv
`default_nettype none
module cme_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] out_byte,
	input wire logic byte_valid,
	input wire logic last,
	input wire logic [1:0] status,
	input wire logic [15:0] message_size
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(message_size) && $stable(last))
		else $error("stalled result changed");

	a_finish_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> last)
		else $error("finish result not marked last");

	a_finish_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == 8'd0)
		else $error("finish result carries a byte");

	a_bytes_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> status == cme_pkg::ST_OK)
		else $error("byte emitted under error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == cme_pkg::ST_OK || status == cme_pkg::ST_TOO_LONG
			|| status == cme_pkg::ST_DESCENDING)
		else $error("undefined status code");

endmodule

bind coap_message_encoder_core cme_checker u_cme_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_byte(out_ch.out_byte),
	.byte_valid(out_ch.byte_valid),
	.last(out_ch.last),
	.status(out_ch.status),
	.message_size(out_ch.message_size)
);
`default_nettype wire
